### src/ntfc_pkg.sv
package ntfc_pkg;

    localparam int PATTERN_DEPTH_DEF = 64;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_ON    = 2'd1;
    localparam logic [1:0] REQ_OFF   = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    // run phases
    localparam logic [1:0] PH_STOP    = 2'd0;
    localparam logic [1:0] PH_START   = 2'd1;
    localparam logic [1:0] PH_PATTERN = 2'd2;
    localparam logic [1:0] PH_GLOW    = 2'd3;

    // pattern modes
    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_DIGITAL = 2'd1;
    localparam logic [1:0] MODE_ANALOG  = 2'd2;

    // register indexes
    localparam logic [2:0] REG_START_DELAY   = 3'd0;
    localparam logic [2:0] REG_PATTERN_MODE  = 3'd1;
    localparam logic [2:0] REG_PATTERN_RHY   = 3'd2;
    localparam logic [2:0] REG_PATTERN_LEN   = 3'd3;
    localparam logic [2:0] REG_USE_DEFAULT   = 3'd4;
    localparam logic [2:0] REG_FAIL_INTERVAL = 3'd5;
    localparam logic [2:0] REG_FAIL_VARIATN  = 3'd6;
    localparam logic [2:0] REG_FAIL_DURATION = 3'd7;

    localparam int CFG_ADDR_W = 5;

    localparam logic [7:0]  RHYTHM_RST   = 8'd25;
    localparam logic [7:0]  DURATION_RST = 8'd10;
    localparam logic [31:0] NOISE_SEED   = 32'hB5AD4ECE;
    localparam logic [31:0] NOISE_TAPS   = 32'hD0000001;
    localparam int          GAP_SCALE    = 100;
    localparam int          DIG_LEN      = 30;
    localparam int          ANA_LEN      = 27;

    localparam int CD_W    = 25;
    localparam int BASE_W  = 23;
    localparam int DVD_W   = 32;
    localparam int RANGE_W = 24;

    typedef struct packed {
        logic [23:0] start_delay;
        logic [1:0]  pattern_mode;
        logic [7:0]  pattern_rhythm;
        logic [6:0]  pattern_length;
        logic        use_default_table;
        logic [15:0] fail_interval;
        logic [7:0]  fail_variation;
        logic [7:0]  fail_duration;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic run;
        logic div_go;
        logic gap;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic need_draw;
        logic div_done;
    } stat_t;

    function automatic logic dig_tbl(input logic [6:0] i);
        logic v;
        case (i)
            7'd0, 7'd1, 7'd10, 7'd11, 7'd12, 7'd18, 7'd19, 7'd20,
            7'd25, 7'd26, 7'd27: v = 1'b1;
            default:             v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] ana_tbl(input logic [6:0] i);
        logic [7:0] v;
        case (i)
            7'd1:    v = 8'd220;
            7'd2:    v = 8'd40;
            7'd3:    v = 8'd10;
            7'd10:   v = 8'd220;
            7'd11:   v = 8'd80;
            7'd12:   v = 8'd20;
            7'd23:   v = 8'd180;
            7'd24:   v = 8'd210;
            7'd25:   v = 8'd230;
            7'd26:   v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### src/ntfc_ram.sv
module ntfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/ntfc_mod_unit.sv
module ntfc_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ntfc_pkg::DVD_W-1:0]    dividend,
    input  logic [ntfc_pkg::RANGE_W-1:0]  divisor,
    output logic [ntfc_pkg::RANGE_W-1:0]  rem,
    output logic                          done
);
    import ntfc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [RANGE_W-1:0]  dsr_reg;
    logic [RANGE_W-1:0]  rem_reg;
    logic [RANGE_W:0]    shifted;
    logic [RANGE_W:0]    diff;

    // one restoring step per cycle, MSB of the dividend first
    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign done    = busy_reg && (cnt_reg == LAST);
    assign rem     = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !done;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_reg <= diff[RANGE_W-1:0];
            end
            else
            begin
                rem_reg <= shifted[RANGE_W-1:0];
            end
        end
    end

endmodule

### src/ntfc_ctrl.sv
module ntfc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  ntfc_pkg::stat_t stat,
    output ntfc_pkg::cmd_t  cmd
);
    import ntfc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_DGO   = 3'd3;
    localparam logic [2:0] S_DWAIT = 3'd4;
    localparam logic [2:0] S_GAP   = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       ovalid_reg;
    logic       ovalid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        ovalid_next = ovalid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.is_write ? S_PUSH : S_RUN;
            end
            S_RUN:
            begin
                cmd.run    = 1'b1;
                state_next = stat.need_draw ? S_DGO : S_PUSH;
            end
            S_DGO:
            begin
                cmd.div_go = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                cmd.gap    = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                // hold until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.push    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

### src/ntfc_datapath.sv
module ntfc_datapath #(
    parameter int PATTERN_DEPTH = ntfc_pkg::PATTERN_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ntfc_pkg::cfg_t  cfg,
    input  ntfc_pkg::cmd_t  cmd,
    output ntfc_pkg::stat_t stat,
    input  logic [1:0]      req_type,
    input  logic [5:0]      entry_index,
    input  logic [7:0]      entry_value,
    output logic [7:0]      led_level,
    output logic            analog_drive,
    output logic [1:0]      phase
);
    import ntfc_pkg::*;

    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam logic [7:0] DEPTH_W = 8'(PATTERN_DEPTH);

    // latched request
    logic [1:0] req_reg;
    logic [5:0] idx_reg;
    logic [7:0] val_reg;

    // run state
    logic [1:0]         phase_reg,  phase_next;
    logic [CD_W-1:0]    cd_reg,     cd_next;
    logic [7:0]         lvl_reg,    lvl_next;
    logic [6:0]         ptr_reg,    ptr_next;
    logic               af_reg,     af_next;
    logic [DVD_W-1:0]   noise_reg,  noise_next;
    logic [BASE_W-1:0]  base_reg;
    logic               rzero_reg;

    // result register
    logic [7:0] led_reg;
    logic       adrv_reg;
    logic [1:0] ph_out_reg;

    logic [7:0]          idx_ext;
    logic [7:0]          ptr_ext;
    logic                ram_we;
    logic [7:0]          ram_rdata;
    logic                digital;
    logic                mode_plays;
    logic                fail_on;
    logic                range_zero;
    logic                draw;
    logic [7:0]          plen_clamp;
    logic [7:0]          size_c;
    logic [7:0]          entry_v;
    logic [RANGE_W-1:0]  range_c;
    logic [RANGE_W-1:0]  rem;
    logic                div_done;

    assign idx_ext    = {2'b00, idx_reg};
    assign ptr_ext    = {1'b0, ptr_reg};
    assign ram_we     = cmd.prep && (req_reg == REQ_WRITE) && (idx_ext < DEPTH_W);
    assign digital    = (cfg.pattern_mode == MODE_DIGITAL);
    assign mode_plays = (cfg.pattern_mode == MODE_DIGITAL) ||
                        (cfg.pattern_mode == MODE_ANALOG);
    assign fail_on    = (cfg.fail_interval != 16'd0);
    assign range_zero = !fail_on || (cfg.fail_variation == 8'd0);
    assign range_c    = RANGE_W'(cfg.fail_interval) * RANGE_W'(cfg.fail_variation);
    assign plen_clamp = ({1'b0, cfg.pattern_length} > DEPTH_W) ? DEPTH_W
                                                              : {1'b0, cfg.pattern_length};
    assign size_c     = cfg.use_default_table ? (digital ? 8'(DIG_LEN) : 8'(ANA_LEN))
                                              : plen_clamp;
    assign entry_v    = cfg.use_default_table
                        ? (digital ? {7'd0, dig_tbl(ptr_reg)} : ana_tbl(ptr_reg))
                        : ram_rdata;

    // a random gap is drawn on the start-to-glow step and on every relight
    always_comb
    begin
        case (phase_reg)
            PH_START: draw = (cd_reg == '0) && !mode_plays && fail_on;
            PH_GLOW:  draw = (cd_reg == '0) && fail_on && (lvl_reg == 8'd0);
            default:  draw = 1'b0;
        endcase
    end

    assign stat.is_write  = (req_reg == REQ_WRITE);
    assign stat.need_draw = draw;
    assign stat.div_done  = div_done;

    ntfc_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (val_reg),
        .raddr (ptr_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    ntfc_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (noise_reg),
        .divisor  (range_c),
        .rem      (rem),
        .done     (div_done)
    );

    always_comb
    begin
        phase_next = phase_reg;
        cd_next    = cd_reg;
        lvl_next   = lvl_reg;
        ptr_next   = ptr_reg;
        af_next    = af_reg;
        noise_next = noise_reg;

        if (cmd.prep)
        begin
            case (req_reg)
                REQ_TICK:
                begin
                    if (cd_reg != '0)
                    begin
                        cd_next = cd_reg - CD_W'(1);
                    end
                end
                REQ_ON:
                begin
                    cd_next    = CD_W'(cfg.start_delay);
                    phase_next = PH_START;
                    ptr_next   = '0;
                    lvl_next   = '0;
                    af_next    = 1'b0;
                end
                REQ_OFF:
                begin
                    phase_next = PH_STOP;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.run)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (cd_reg == '0)
                    begin
                        if (mode_plays)
                        begin
                            phase_next = PH_PATTERN;
                            cd_next    = CD_W'(cfg.pattern_rhythm);
                        end
                        else
                        begin
                            lvl_next   = 8'd1;
                            af_next    = 1'b0;
                            phase_next = PH_GLOW;
                        end
                    end
                end
                PH_PATTERN:
                begin
                    if (cd_reg == '0)
                    begin
                        cd_next = CD_W'(cfg.pattern_rhythm);
                        if (ptr_ext >= size_c)
                        begin
                            lvl_next   = 8'd1;
                            af_next    = 1'b0;
                            phase_next = PH_GLOW;
                        end
                        else
                        begin
                            if (entry_v != lvl_reg)
                            begin
                                lvl_next = entry_v;
                                af_next  = !digital;
                            end
                            ptr_next = ptr_reg + 7'd1;
                        end
                    end
                end
                PH_GLOW:
                begin
                    if (fail_on && (cd_reg == '0))
                    begin
                        af_next = 1'b0;
                        if (lvl_reg != 8'd0)
                        begin
                            lvl_next = 8'd0;
                            cd_next  = CD_W'(cfg.fail_duration);
                        end
                        else
                        begin
                            lvl_next = 8'd1;
                        end
                    end
                end
                default:
                begin
                    lvl_next = 8'd0;
                    af_next  = 1'b0;
                end
            endcase

            // advance the noise word only when a nonzero range is drawn
            if (draw && !range_zero)
            begin
                noise_next = {1'b0, noise_reg[DVD_W-1:1]} ^
                             (noise_reg[0] ? NOISE_TAPS : '0);
            end
        end

        if (cmd.gap)
        begin
            cd_next = CD_W'(base_reg) + (rzero_reg ? CD_W'(0) : CD_W'(rem));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOP;
            cd_reg    <= '0;
            lvl_reg   <= '0;
            ptr_reg   <= '0;
            af_reg    <= 1'b0;
            noise_reg <= NOISE_SEED;
        end
        else
        begin
            phase_reg <= phase_next;
            cd_reg    <= cd_next;
            lvl_reg   <= lvl_next;
            ptr_reg   <= ptr_next;
            af_reg    <= af_next;
            noise_reg <= noise_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg <= req_type;
            idx_reg <= entry_index;
            val_reg <= entry_value;
        end
        if (cmd.run && draw)
        begin
            base_reg  <= BASE_W'(cfg.fail_interval) * BASE_W'(GAP_SCALE);
            rzero_reg <= range_zero;
        end
        if (cmd.push)
        begin
            led_reg    <= af_reg ? lvl_reg : {7'd0, (lvl_reg != 8'd0)};
            adrv_reg   <= af_reg;
            ph_out_reg <= phase_reg;
        end
    end

    assign led_level    = led_reg;
    assign analog_drive = adrv_reg;
    assign phase        = ph_out_reg;

endmodule

### src/neon_tube_flicker_controller.sv
// Neon tube flicker controller. Each input beat is one request: a one
// millisecond tick, switch on, switch off, or a write into the custom pattern
// table; every request returns exactly one result beat with the LED level,
// the analog flag and the run phase. A write goes from acceptance through
// prepare to push; a request that only runs the phase logic also passes the run
// step; a request that draws a new random dropout gap also passes through the
// 32-step restoring modulo that reduces the noise word by the random range,
// one quotient bit per cycle. One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// The custom pattern lives in a RAM with a registered read and is not
// cleared: entries that were never written read back as garbage. Registers
// sit on the APB port at byte address 4*i and may be changed only while
// the block is idle.
module neon_tube_flicker_controller #(
    parameter int PATTERN_DEPTH = ntfc_pkg::PATTERN_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // entry_index[5:0], entry_value[13:6]
    input  logic [1:0]                      s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,  // led_level[7:0], phase[9:8]
    output logic [0:0]                      m_axis_tuser,  // analog_drive[0]
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ntfc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ntfc_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    stat_t      stat;
    logic [2:0] reg_idx;
    logic       cfg_wr;
    logic [7:0] led_level;
    logic       analog_drive;
    logic [1:0] phase;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register file: written in the access cycle, low address bits ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay       <= '0;
            cfg_reg.pattern_mode      <= MODE_NONE;
            cfg_reg.pattern_rhythm    <= RHYTHM_RST;
            cfg_reg.pattern_length    <= '0;
            cfg_reg.use_default_table <= 1'b1;
            cfg_reg.fail_interval     <= '0;
            cfg_reg.fail_variation    <= '0;
            cfg_reg.fail_duration     <= DURATION_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_START_DELAY:   cfg_reg.start_delay       <= pwdata[23:0];
                REG_PATTERN_MODE:  cfg_reg.pattern_mode      <= pwdata[1:0];
                REG_PATTERN_RHY:   cfg_reg.pattern_rhythm    <= pwdata[7:0];
                REG_PATTERN_LEN:   cfg_reg.pattern_length    <= pwdata[6:0];
                REG_USE_DEFAULT:   cfg_reg.use_default_table <= pwdata[0];
                REG_FAIL_INTERVAL: cfg_reg.fail_interval     <= pwdata[15:0];
                REG_FAIL_VARIATN:  cfg_reg.fail_variation    <= pwdata[7:0];
                REG_FAIL_DURATION: cfg_reg.fail_duration     <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, zero-extended
    always_comb
    begin
        case (reg_idx)
            REG_START_DELAY:   prdata = 32'(cfg_reg.start_delay);
            REG_PATTERN_MODE:  prdata = 32'(cfg_reg.pattern_mode);
            REG_PATTERN_RHY:   prdata = 32'(cfg_reg.pattern_rhythm);
            REG_PATTERN_LEN:   prdata = 32'(cfg_reg.pattern_length);
            REG_USE_DEFAULT:   prdata = 32'(cfg_reg.use_default_table);
            REG_FAIL_INTERVAL: prdata = 32'(cfg_reg.fail_interval);
            REG_FAIL_VARIATN:  prdata = 32'(cfg_reg.fail_variation);
            REG_FAIL_DURATION: prdata = 32'(cfg_reg.fail_duration);
            default:           prdata = '0;
        endcase
    end

    // sequencer: accept, prepare, run the phase (skipped for a write), optional gap draw, push
    ntfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // phase state, pattern RAM, noise word, modulo unit, result register
    ntfc_datapath #(
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (s_axis_tuser),
        .entry_index  (s_axis_tdata[5:0]),
        .entry_value  (s_axis_tdata[13:6]),
        .led_level    (led_level),
        .analog_drive (analog_drive),
        .phase        (phase)
    );

    assign m_axis_tdata = {6'd0, phase, led_level};
    assign m_axis_tuser = analog_drive;

endmodule

### src/ntfc_checker.sv
module ntfc_assertions (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);
    import ntfc_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in work");

    // a digital level is 0 or 1
    a_digital_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:1] == 7'd0)
        else $error("digital level out of range");

    // stopped means dark and digital
    a_stopped_dark: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] == PH_STOP)
            |-> (m_axis_tdata[7:0] == 8'd0) && !m_axis_tuser[0])
        else $error("stopped tube not dark");

    // analog drive only while a pattern plays
    a_analog_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[9:8] == PH_PATTERN)
        else $error("analog drive outside pattern phase");

endmodule

bind neon_tube_flicker_controller ntfc_assertions u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
